// File: src/pid3_pkg.sv
// ----------------------------------------------------------------------------
// pid3_pkg
// Shared types, register codes and the saturation helper of the position hold block.
// ----------------------------------------------------------------------------
package pid3_pkg;

  localparam int unsigned MaxAxes = 3;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_TGT_X  = 3'd3,
    REG_TGT_Y  = 3'd4,
    REG_TGT_Z  = 3'd5,
    REG_RADIUS = 3'd6,
    REG_NONE   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_CHECK,
    T_RUN,
    T_HOLD
  } top_state_e;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_ACC,
    L_IMUL,
    L_DIV,
    L_SUM
  } lane_state_e;

  // Status that one lane reports to the merging stage.
  typedef struct packed {
    logic in_box;
    logic done;
  } lane_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: src/pid3_if.sv
// ----------------------------------------------------------------------------
// pid3_if
// Request channels of the position hold block: measured positions in,
// velocity commands out.
// ----------------------------------------------------------------------------
interface pid3_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [15:0] step_time;

  modport source (output valid, pos_x, pos_y, pos_z, step_time, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, step_time, output ready);
endinterface

interface pid3_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic               arrived;

  modport source (output valid, vel_x, vel_y, vel_z, arrived, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, arrived, output ready);
endinterface

// File: src/pid3_lane.sv
// ----------------------------------------------------------------------------
// pid3_lane
// One axis of the controller: arrival test, integrator with sign-change
// clear, and a bit-serial divider for the derivative term.
// ----------------------------------------------------------------------------
module pid3_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [31:0]   pos_i,
  input  logic        [15:0]   dt_i,
  input  logic signed [31:0]   target_i,
  input  logic        [30:0]   radius_i,
  input  logic signed [15:0]   kp_i,
  input  logic signed [15:0]   ki_i,
  input  logic signed [15:0]   kd_i,
  output pid3_pkg::lane_stat_t stat_o,
  output logic signed [31:0]   vel_o
);

  localparam int unsigned QW = 56;

  pid3_pkg::lane_state_e state_q, state_d;

  logic signed [31:0] prev_q, integ_q;
  logic signed [31:0] e_q, ibase_q;
  logic        [15:0] dt_q;
  logic signed [48:0] edt_q, dprod_q;
  logic signed [47:0] pprod_q, iprod_q;
  logic               neg_q;
  logic      [QW-1:0] quo_q;
  logic        [15:0] rem_q;
  logic         [5:0] cnt_q;
  logic signed [31:0] vel_q;
  logic               done_q;

  logic signed [32:0] pos_dist, dist_abs, e_full, diff;
  logic signed [31:0] e_sat, integ_new;
  logic        [15:0] dt_div;
  logic        [16:0] trial;
  logic               ge;
  logic        [48:0] mag;
  logic signed [QW:0] quot;

  always_comb begin
    pos_dist = {pos_i[31], pos_i} - {target_i[31], target_i};
    dist_abs = pos_dist[32] ? -pos_dist : pos_dist;
    e_full   = {target_i[31], target_i} - {pos_i[31], pos_i};
    e_sat    = pid3_pkg::sat32(64'(e_full));
    diff     = {e_q[31], e_q} - {prev_q[31], prev_q};
    integ_new = pid3_pkg::sat32(64'(ibase_q) + 64'(edt_q >>> 16));
    dt_div   = (dt_q == 16'd0) ? 16'd1 : dt_q;
    trial    = {rem_q, quo_q[QW-1]};
    ge       = trial >= {1'b0, dt_div};
    mag      = dprod_q[48] ? -dprod_q : dprod_q;
    quot     = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pid3_pkg::L_IDLE: if (start_i) state_d = pid3_pkg::L_MUL;
      pid3_pkg::L_MUL:  state_d = pid3_pkg::L_ACC;
      pid3_pkg::L_ACC:  state_d = pid3_pkg::L_IMUL;
      pid3_pkg::L_IMUL: state_d = pid3_pkg::L_DIV;
      pid3_pkg::L_DIV:  if (cnt_q == 6'(QW - 1)) state_d = pid3_pkg::L_SUM;
      pid3_pkg::L_SUM:  state_d = pid3_pkg::L_IDLE;
      default:          state_d = pid3_pkg::L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pid3_pkg::L_IDLE;
      prev_q  <= '0;
      integ_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == pid3_pkg::L_SUM);
      if (state_q == pid3_pkg::L_ACC) begin
        integ_q <= integ_new;
        prev_q  <= e_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      pid3_pkg::L_IDLE: begin
        e_q  <= e_sat;
        dt_q <= dt_i;
      end
      pid3_pkg::L_MUL: begin
        // The integrator restarts when the error strictly changes sign.
        if ((prev_q < 0 && e_q > 0) || (prev_q > 0 && e_q < 0)) begin
          ibase_q <= '0;
        end else begin
          ibase_q <= integ_q;
        end
        edt_q   <= e_q * $signed({1'b0, dt_q});
        pprod_q <= kp_i * e_q;
        dprod_q <= kd_i * diff;
      end
      pid3_pkg::L_ACC: begin
        neg_q <= dprod_q[48];
        quo_q <= {mag[47:0], 8'd0};
        rem_q <= '0;
        cnt_q <= '0;
      end
      pid3_pkg::L_IMUL: begin
        iprod_q <= ki_i * integ_q;
      end
      pid3_pkg::L_DIV: begin
        rem_q <= ge ? 16'(trial - {1'b0, dt_div}) : trial[15:0];
        quo_q <= {quo_q[QW-2:0], ge};
        cnt_q <= cnt_q + 6'd1;
      end
      pid3_pkg::L_SUM: begin
        vel_q <= pid3_pkg::sat32(64'(pprod_q >>> 8) + 64'(quot) + 64'(iprod_q >>> 8));
      end
      default: ;
    endcase
  end

  assign stat_o.in_box = dist_abs < $signed({2'b00, radius_i});
  assign stat_o.done   = done_q;
  assign vel_o         = vel_q;

endmodule

// File: src/three_axis_pid_position_hold.sv
// ----------------------------------------------------------------------------
// three_axis_pid_position_hold
// Per-axis PID position hold with integrator clear on error sign change.
// ----------------------------------------------------------------------------
// Usage: positions and step time arrive as a request on in_ch; the command
// leaves as a request on out_ch. The user writes gains, targets and the arrival
// radius over the APB port (64-bit data, register i at byte address 8*i) only
// while the block is idle; the block itself does not enforce this.
// One lane per axis works on its axis; a merging stage collects the lanes.
// If every active axis lies strictly inside the arrival box the result is
// zero velocities with arrived set, and the controller state is left alone.
// Otherwise each lane runs a 56-step bit-serial divider for the derivative
// term; a new item is accepted only once the current result has moved on
// into the output register.
// The output register holds a result until the receiver takes it; the
// next item can be accepted meanwhile, and its result waits in the merge
// stage until the output register frees up.
// Reset clears the configuration registers, the output valid, the integrators and the previous errors.
// ----------------------------------------------------------------------------
module three_axis_pid_position_hold #(
  parameter int unsigned NUM_AXES = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pid3_in_if.sink     in_ch,
  pid3_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  pid3_pkg::top_state_e state_q, state_d;

  logic [47:0] kp_q, ki_q, kd_q;
  logic signed [31:0] tgt_q [pid3_pkg::MaxAxes];
  logic [30:0] radius_q;

  logic signed [31:0] pos_q [pid3_pkg::MaxAxes];
  logic        [15:0] dt_q;

  logic signed [31:0] res_vel_q [pid3_pkg::MaxAxes];
  logic               res_arr_q;

  logic               out_valid_q;
  logic signed [31:0] out_vel_q [pid3_pkg::MaxAxes];
  logic               out_arr_q;

  pid3_pkg::lane_stat_t stat [NUM_AXES];
  logic signed [31:0]   lane_vel [NUM_AXES];
  logic [NUM_AXES-1:0]  inside_v, done_v;
  logic                 lane_start;

  pid3_pkg::reg_idx_e widx;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign widx   = pid3_pkg::reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      tgt_q[0] <= '0;
      tgt_q[1] <= '0;
      tgt_q[2] <= '0;
      radius_q <= '0;
    end else if (wr_en) begin
      case (widx)
        pid3_pkg::REG_KP:     kp_q     <= pwdata[47:0];
        pid3_pkg::REG_KI:     ki_q     <= pwdata[47:0];
        pid3_pkg::REG_KD:     kd_q     <= pwdata[47:0];
        pid3_pkg::REG_TGT_X:  tgt_q[0] <= pwdata[31:0];
        pid3_pkg::REG_TGT_Y:  tgt_q[1] <= pwdata[31:0];
        pid3_pkg::REG_TGT_Z:  tgt_q[2] <= pwdata[31:0];
        pid3_pkg::REG_RADIUS: radius_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pid3_pkg::reg_idx_e'(paddr[5:3]))
      pid3_pkg::REG_KP:     prdata = {16'd0, kp_q};
      pid3_pkg::REG_KI:     prdata = {16'd0, ki_q};
      pid3_pkg::REG_KD:     prdata = {16'd0, kd_q};
      pid3_pkg::REG_TGT_X:  prdata = {32'd0, tgt_q[0]};
      pid3_pkg::REG_TGT_Y:  prdata = {32'd0, tgt_q[1]};
      pid3_pkg::REG_TGT_Z:  prdata = {32'd0, tgt_q[2]};
      pid3_pkg::REG_RADIUS: prdata = {33'd0, radius_q};
      default:              prdata = '0;
    endcase
  end

  assign lane_start = (state_q == pid3_pkg::T_CHECK) && !(&inside_v);

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    pid3_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .start_i  (lane_start),
      .pos_i    (pos_q[g]),
      .dt_i     (dt_q),
      .target_i (tgt_q[g]),
      .radius_i (radius_q),
      .kp_i     (kp_q[16*g +: 16]),
      .ki_i     (ki_q[16*g +: 16]),
      .kd_i     (kd_q[16*g +: 16]),
      .stat_o   (stat[g]),
      .vel_o    (lane_vel[g])
    );
    assign inside_v[g] = stat[g].in_box;
    assign done_v[g]   = stat[g].done;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pid3_pkg::T_IDLE:  if (in_ch.valid) state_d = pid3_pkg::T_CHECK;
      pid3_pkg::T_CHECK: state_d = (&inside_v) ? pid3_pkg::T_HOLD : pid3_pkg::T_RUN;
      pid3_pkg::T_RUN:   if (&done_v) state_d = pid3_pkg::T_HOLD;
      pid3_pkg::T_HOLD:  if (!out_valid_q || out_ch.ready) state_d = pid3_pkg::T_IDLE;
      default:           state_d = pid3_pkg::T_IDLE;
    endcase
  end

  assign in_ch.ready = (state_q == pid3_pkg::T_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pid3_pkg::T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == pid3_pkg::T_HOLD && (!out_valid_q || out_ch.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      pos_q[0] <= in_ch.pos_x;
      pos_q[1] <= in_ch.pos_y;
      pos_q[2] <= in_ch.pos_z;
      dt_q     <= in_ch.step_time;
    end
    // Merge stage: collect the lanes; axes beyond NUM_AXES report zero.
    if (state_q == pid3_pkg::T_CHECK && (&inside_v)) begin
      res_arr_q <= 1'b1;
      for (int a = 0; a < pid3_pkg::MaxAxes; a++) res_vel_q[a] <= '0;
    end else if (state_q == pid3_pkg::T_RUN && (&done_v)) begin
      res_arr_q <= 1'b0;
      for (int a = 0; a < pid3_pkg::MaxAxes; a++) begin
        res_vel_q[a] <= (a < NUM_AXES) ? lane_vel[a] : '0;
      end
    end
    if (state_q == pid3_pkg::T_HOLD && (!out_valid_q || out_ch.ready)) begin
      out_vel_q <= res_vel_q;
      out_arr_q <= res_arr_q;
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.vel_x   = out_vel_q[0];
  assign out_ch.vel_y   = out_vel_q[1];
  assign out_ch.vel_z   = out_vel_q[2];
  assign out_ch.arrived = out_arr_q;

endmodule

// File: src/pid3_checker.sv
// ----------------------------------------------------------------------------
// pid3_checker
// Port-level checks of the position hold block, bound to the top level.
// ----------------------------------------------------------------------------
module pid3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] vel_x,
  input logic [31:0] vel_y,
  input logic [31:0] vel_z,
  input logic        arrived
);

  // A request on the output is never dropped while the receiver stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  // An arrived result always carries zero commands.
  a_arrived_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && arrived |-> vel_x == 32'd0 && vel_y == 32'd0 && vel_z == 32'd0)
    else $error("arrived result with nonzero velocity");

  // One item at a time: an accept closes the input side.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // No result can appear the cycle right after an accept into an empty block.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind three_axis_pid_position_hold pid3_checker u_pid3_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .vel_x     (out_ch.vel_x),
  .vel_y     (out_ch.vel_y),
  .vel_z     (out_ch.vel_z),
  .arrived   (out_ch.arrived)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the position hold block against a predictor of its PID arithmetic,
// with random bursts on the request side and stalls on the command side.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] vz;
  logic               arr;
} vel_cmd_t;

class pid_scoreboard;
  logic [47:0]        kp, ki, kd;
  logic signed [31:0] tgt [3];
  logic [30:0]        radius;
  logic signed [31:0] prev_err [3];
  logic signed [31:0] integ [3];
  vel_cmd_t           pending [$];
  int                 errors;

  function new();
    kp = '0; ki = '0; kd = '0; radius = '0;
    for (int a = 0; a < 3; a++) begin
      tgt[a] = '0; prev_err[a] = '0; integ[a] = '0;
    end
    errors = 0;
  endfunction

  function void set_reg(pid3_pkg::reg_idx_e idx, logic [63:0] v);
    case (idx)
      pid3_pkg::REG_KP: kp = v[47:0];
      pid3_pkg::REG_KI: ki = v[47:0];
      pid3_pkg::REG_KD: kd = v[47:0];
      pid3_pkg::REG_TGT_X: tgt[0] = v[31:0];
      pid3_pkg::REG_TGT_Y: tgt[1] = v[31:0];
      pid3_pkg::REG_TGT_Z: tgt[2] = v[31:0];
      pid3_pkg::REG_RADIUS: radius = v[30:0];
      default: ;
    endcase
  endfunction

  function logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Arithmetic shift right is a floor division by a power of two.
  function void note_request(logic signed [31:0] pos [3], logic [15:0] dt);
    vel_cmd_t c;
    logic signed [63:0] d, e, pv, iv, p, dd, it, v, g, dtd, dts, vel [3];
    bit in_box;
    in_box = 1;
    for (int a = 0; a < 3; a++) begin
      d = 64'(pos[a]) - 64'(tgt[a]);
      if (d < 0) d = -d;
      if (!(d < 64'(radius))) in_box = 0;
      vel[a] = 0;
    end
    if (in_box) begin
      c.vx = 0; c.vy = 0; c.vz = 0; c.arr = 1;
      pending = {pending, c};
      return;
    end
    dts = $signed(64'(dt));
    dtd = (dt == 0) ? 64'sd1 : dts;
    for (int a = 0; a < 3; a++) begin
      e = clamp32(64'(tgt[a]) - 64'(pos[a]));
      pv = prev_err[a];
      iv = integ[a];
      if ((pv < 0 && e > 0) || (pv > 0 && e < 0)) iv = 0;
      iv = clamp32(iv + ((e * dts) >>> 16));
      g = $signed(kp[16*a +: 16]);
      p = (g * e) >>> 8;
      g = $signed(kd[16*a +: 16]);
      dd = (g * (e - pv) * 256) / dtd;
      g = $signed(ki[16*a +: 16]);
      it = (g * iv) >>> 8;
      v = clamp32(p + dd + it);
      vel[a] = v;
      integ[a] = iv[31:0];
      prev_err[a] = e[31:0];
    end
    c.vx = vel[0][31:0]; c.vy = vel[1][31:0]; c.vz = vel[2][31:0]; c.arr = 0;
    pending = {pending, c};
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task check_command(vel_cmd_t got);
    vel_cmd_t w;
    if (pending.size() == 0) begin
      report("unexpected command", '0, '0);
      return;
    end
    w = pending.pop_front();
    if (got.vx !== w.vx) report("vel_x", 64'(got.vx), 64'(w.vx));
    if (got.vy !== w.vy) report("vel_y", 64'(got.vy), 64'(w.vy));
    if (got.vz !== w.vz) report("vel_z", 64'(got.vz), 64'(w.vz));
    if (got.arr !== w.arr) report("arrived", 64'(got.arr), 64'(w.arr));
  endtask
endclass

module tb_top;
  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  pid3_in_if in_ch ();
  pid3_out_if out_ch ();

  three_axis_pid_position_hold i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  pid_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  long_hold = 0;
  bit  rx_stall = 0;

  initial begin
    in_ch.valid = 0; in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.pos_z = 0;
    in_ch.step_time = 1;
    out_ch.ready = 0;
  end

  // Command side: stall pattern plus one long hold-off.
  initial begin
    int hold;
    @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ch.ready <= 0;
        for (hold = 0; hold < 400; hold++) @(posedge clk_i);
        long_hold = 0;
      end
      out_ch.ready <= rx_stall ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    vel_cmd_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.vx = out_ch.vel_x; got.vy = out_ch.vel_y; got.vz = out_ch.vel_z;
      got.arr = out_ch.arrived;
      sb.check_command(got);
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 5000) begin
      $display("three_axis_pid_position_hold test failed");
      $finish;
    end
  end

  task automatic write_reg(pid3_pkg::reg_idx_e idx, logic [63:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_pos(logic signed [31:0] x, y, z, logic [15:0] dt);
    logic signed [31:0] p [3];
    in_ch.valid <= 1; in_ch.pos_x <= x; in_ch.pos_y <= y; in_ch.pos_z <= z;
    in_ch.step_time <= dt;
    do @(posedge clk_i); while (!in_ch.ready);
    p[0] = x; p[1] = y; p[2] = z;
    sb.note_request(p, dt);
  endtask

  task automatic pause_tx();
    int gap;
    gap = $urandom_range(0, 2) == 0 ? $urandom_range(1, 80) : 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_pos(logic signed [31:0] t);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return t + $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  function automatic logic [47:0] rnd_gain(int mode);
    if (mode == 0) return 48'({$urandom, $urandom});
    if (mode == 1) return 48'h7fff_8000_7fff;
    return {3{16'($urandom_range(0, 16'h0400)) - 16'h0200}};
  endfunction

  initial begin
    int burst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: all gains zero, then moderate, then extreme; arrival box; zero step time.
    send_pos(0, 0, 0, 1);
    drain();
    write_reg(pid3_pkg::REG_KP, 48'h0100_0100_0100);
    write_reg(pid3_pkg::REG_KI, 48'h0080_ff80_0040);
    write_reg(pid3_pkg::REG_KD, 48'h0010_0020_fff0);
    write_reg(pid3_pkg::REG_TGT_X, 32'h0001_0000);
    write_reg(pid3_pkg::REG_TGT_Y, 32'hffff_0000);
    write_reg(pid3_pkg::REG_TGT_Z, 32'h7fff_ffff);
    write_reg(pid3_pkg::REG_RADIUS, 31'h0000_8000);
    send_pos(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'hffff);
    send_pos(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1);
    send_pos(32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff, 16'h0100);
    send_pos(32'h0001_7fff, 32'hffff_0000, 32'h7fff_ffff, 16'h0100);
    send_pos(32'h0001_8000, 32'hffff_0000, 32'h7fff_ffff, 16'h0100);
    send_pos(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    send_pos(32'h0002_0000, 32'hfffe_0000, 32'h0000_0000, 16'h0040);
    drain();
    write_reg(pid3_pkg::REG_KP, 48'h7fff_7fff_7fff);
    write_reg(pid3_pkg::REG_KI, 48'h8000_8000_8000);
    write_reg(pid3_pkg::REG_KD, 48'h7fff_8000_7fff);
    write_reg(pid3_pkg::REG_RADIUS, 31'h7fff_ffff);
    send_pos(0, 0, 0, 1);
    drain();
    write_reg(pid3_pkg::REG_RADIUS, 0);
    send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_pos(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
    send_pos(32'h1234_5678, 32'h8765_4321, 32'h0, 16'h8000);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      write_reg(pid3_pkg::REG_KP, rnd_gain(phase % 3));
      write_reg(pid3_pkg::REG_KI, rnd_gain((phase + 1) % 3));
      write_reg(pid3_pkg::REG_KD, rnd_gain((phase + 2) % 3));
      write_reg(pid3_pkg::REG_TGT_X, phase == 6 ? 32'h8000_0000 : $urandom);
      write_reg(pid3_pkg::REG_TGT_Y,
                phase == 6 ? 32'h7fff_ffff : $urandom_range(0, 32'hfffff));
      write_reg(pid3_pkg::REG_TGT_Z, $urandom);
      write_reg(pid3_pkg::REG_RADIUS,
                phase == 5 ? 31'h7fff_ffff : $urandom_range(0, 32'h20000));
      rx_stall = (phase == 3);
      if (phase == 2) long_hold = 1;
      for (int n = 0; n < 100; n += burst) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst; k++) begin
          send_pos(rnd_pos(sb.tgt[0]), rnd_pos(sb.tgt[1]), rnd_pos(sb.tgt[2]),
                   $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 1) ? 1 : 16'hffff)
                                             : 16'($urandom_range(1, 16'hffff)));
          // The block holds two results at most while the receiver is stalled.
          if (phase == 3 && n + k == 1) rx_stall = 0;
        end
        pause_tx();
      end
      rx_stall = 0;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("three_axis_pid_position_hold test passed");
    end else begin
      $display("three_axis_pid_position_hold test failed");
    end
    $finish;
  end
endmodule
